// File: hdl/mlfq_task_scheduler_top_assert.svh
// assertion macros for the feedback scheduler
`ifndef MLFQ_TASK_SCHEDULER_TOP_ASSERT_SVH
`define MLFQ_TASK_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTH
`define MLFQ_CHECK(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mlfq check failed");
`define MLFQ_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfq implication failed");
`define MLFQ_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfq sequence failed");
`else
`define MLFQ_CHECK(name, cond)
`define MLFQ_IMPLY(name, ante, cons)
`define MLFQ_NEXT(name, ante, cons)
`endif
`endif

// File: hdl/mlfq_pkg.sv
// shared codes of the feedback scheduler
package mlfq_pkg;
  typedef logic [2:0] op_t;
  localparam op_t OP_TICK    = 3'd0;
  localparam op_t OP_CREATE  = 3'd1;
  localparam op_t OP_SETLVL  = 3'd2;
  localparam op_t OP_UNBLOCK = 3'd3;
  localparam op_t OP_BLOCK   = 3'd4;
  localparam op_t OP_KILL    = 3'd5;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OC_RUN   = 2'd0;
  localparam outcome_t OC_YIELD = 2'd1;
  localparam outcome_t OC_BLOCK = 2'd2;
  localparam outcome_t OC_TERM  = 2'd3;

  typedef logic [1:0] tstate_t;
  localparam tstate_t TS_FREE    = 2'd0;
  localparam tstate_t TS_READY   = 2'd1;
  localparam tstate_t TS_BLOCKED = 2'd2;
  localparam tstate_t TS_RUNNING = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t SC_OK       = 2'd0;
  localparam status_t SC_NOTFOUND = 2'd1;
  localparam status_t SC_INUSE    = 2'd2;

  typedef logic [2:0] regidx_t;
  localparam regidx_t RI_QUANT0 = 3'd0;
  localparam regidx_t RI_QUANT1 = 3'd1;
  localparam regidx_t RI_QUANT2 = 3'd2;
  localparam regidx_t RI_QUANT3 = 3'd3;
  localparam regidx_t RI_AGING  = 3'd4;
endpackage

// File: hdl/mlfq_task_scheduler_top.sv
// four-level feedback scheduler with aging, task table in one memory
// One item is taken at a time. Each task's level, used ticks, state and queue
// links sit in one word of a memory with one write and one registered read
// port; queue heads, tails and counts are in flip-flops. An item turned away by
// a state check ends after decode; create, unblock, block, set level and tick
// work through the read-modify-write steps of the queue link updates on the
// single memory port. A tick that ends an aging period also runs the
// relabelling sweep through the memory. A per-entry valid bit makes every
// never-written task read as free, so no clearing pass follows reset. The
// result is held in an output register until taken.
`include "mlfq_task_scheduler_top_assert.svh"
module mlfq_task_scheduler_top
  import mlfq_pkg::*;
#(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_outcome,
  input  logic [5:0]  in_task_id,
  input  logic [7:0]  in_new_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_running_task,
  output logic        out_idle,
  output logic [1:0]  out_running_level,
  output logic        out_dispatched,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef struct packed {
    logic [1:0]    lvl;
    logic [7:0]    used;
    tstate_t       st;
    logic [IW-1:0] nxt;
    logic [IW-1:0] prv;
  } tw_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_AGE, S_AG1, S_AG2, S_AG3, S_SWP, S_SETTLE, S_TKD,
    S_NEXT, S_UNL, S_UNL2, S_UNL3, S_PUSH, S_PUSH2, S_WR, S_DISP, S_DISP2, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  outcome_t oc_r, oc_nxt;
  logic [1:0] nl_r, nl_nxt;
  logic idok_r, idok_nxt;
  status_t stat_r, stat_nxt;
  logic disp_r, disp_nxt;
  tw_t tw_r, tw_nxt;
  logic [IW-1:0] t_r, t_nxt;
  logic f_unl_r, f_unl_nxt, f_push_r, f_push_nxt, f_wr_r, f_wr_nxt, f_disp_r, f_disp_nxt;
  logic [1:0] ul_r, ul_nxt, pl_r, pl_nxt, dl_r, dl_nxt;
  logic [IW-1:0] qh_r [4];
  logic [IW-1:0] qh_nxt [4];
  logic [IW-1:0] qt_r [4];
  logic [IW-1:0] qt_nxt [4];
  logic [CW-1:0] qc_r [4];
  logic [CW-1:0] qc_nxt [4];
  logic [IW-1:0] cur_r, cur_nxt;
  logic cur_v_r, cur_v_nxt;
  logic [1:0] cur_lvl_r, cur_lvl_nxt;
  logic [15:0] age_r, age_nxt;
  logic [7:0] quant_r [4];
  logic [7:0] quant_nxt [4];
  logic [15:0] period_r, period_nxt;
  logic [CW-1:0] sw_r, sw_nxt;
  logic [MAX_TASKS-1:0] vld_r, vld_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [5:0] out_task_r, out_task_nxt;
  logic out_idle_r, out_idle_nxt;
  logic [1:0] out_lvl_r, out_lvl_nxt;
  logic out_disp_r, out_disp_nxt;
  status_t out_stat_r, out_stat_nxt;

  // memory ports
  tw_t mem [MAX_TASKS];
  tw_t rd_r;
  logic rvld_r;
  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  tw_t mem_wdata;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_running_task = out_task_r;
  assign out_idle = out_idle_r;
  assign out_running_level = out_lvl_r;
  assign out_dispatched = out_disp_r;
  assign out_status = out_stat_r;

  // register read back
  always_comb begin
    case (regidx_t'(cfg_paddr[4:2]))
      RI_QUANT0: cfg_prdata = {24'd0, quant_r[0]};
      RI_QUANT1: cfg_prdata = {24'd0, quant_r[1]};
      RI_QUANT2: cfg_prdata = {24'd0, quant_r[2]};
      RI_QUANT3: cfg_prdata = {24'd0, quant_r[3]};
      RI_AGING:  cfg_prdata = {16'd0, period_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // task table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  // sequencer next state
  always_comb begin
    tstate_t rst;
    logic [1:0] lv;
    logic [7:0] u2;
    logic found;
    logic [1:0] fl;
    logic shift;
    logic [CW-1:0] swm1;

    state_nxt = state_r;
    op_nxt = op_r;
    oc_nxt = oc_r;
    nl_nxt = nl_r;
    idok_nxt = idok_r;
    stat_nxt = stat_r;
    disp_nxt = disp_r;
    tw_nxt = tw_r;
    t_nxt = t_r;
    f_unl_nxt = f_unl_r;
    f_push_nxt = f_push_r;
    f_wr_nxt = f_wr_r;
    f_disp_nxt = f_disp_r;
    ul_nxt = ul_r;
    pl_nxt = pl_r;
    dl_nxt = dl_r;
    qh_nxt = qh_r;
    qt_nxt = qt_r;
    qc_nxt = qc_r;
    cur_nxt = cur_r;
    cur_v_nxt = cur_v_r;
    cur_lvl_nxt = cur_lvl_r;
    age_nxt = age_r;
    quant_nxt = quant_r;
    period_nxt = period_r;
    sw_nxt = sw_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_task_nxt = out_task_r;
    out_idle_nxt = out_idle_r;
    out_lvl_nxt = out_lvl_r;
    out_disp_nxt = out_disp_r;
    out_stat_nxt = out_stat_r;
    mem_we = 1'b0;
    mem_waddr = t_r;
    mem_wdata = tw_r;
    mem_raddr = t_r;
    rst = rvld_r ? rd_r.st : TS_FREE;
    lv = rd_r.lvl;
    u2 = (rd_r.used == 8'hFF) ? 8'hFF : rd_r.used + 8'd1;
    found = 1'b0;
    fl = 2'd0;
    shift = 1'b0;
    swm1 = sw_r - CW'(1);

    // configuration writes
    if (cfg_wr) begin
      case (regidx_t'(cfg_paddr[4:2]))
        RI_QUANT0: quant_nxt[0] = cfg_pwdata[7:0];
        RI_QUANT1: quant_nxt[1] = cfg_pwdata[7:0];
        RI_QUANT2: quant_nxt[2] = cfg_pwdata[7:0];
        RI_QUANT3: quant_nxt[3] = cfg_pwdata[7:0];
        RI_AGING:  period_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end

    case (state_r)
      // take an item and read its task word
      S_IDLE: begin
        mem_raddr = IW'(in_task_id);
        if (in_valid) begin
          op_nxt = in_opcode;
          oc_nxt = in_outcome;
          nl_nxt = in_new_level[1:0];
          t_nxt = IW'(in_task_id);
          idok_nxt = (32'(in_task_id) < MAX_TASKS);
          stat_nxt = SC_OK;
          disp_nxt = 1'b0;
          f_unl_nxt = 1'b0;
          f_push_nxt = 1'b0;
          f_wr_nxt = 1'b0;
          f_disp_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      // decode against the task state
      S_DEC: begin
        tw_nxt = rd_r;
        tw_nxt.st = rst;
        state_nxt = S_NEXT;
        if (op_r == OP_TICK) begin
          state_nxt = S_AGE;
        end else if (op_r > OP_KILL) begin
          state_nxt = S_FIN;
        end else if (!idok_r) begin
          stat_nxt = SC_NOTFOUND;
          state_nxt = S_FIN;
        end else begin
          case (op_r)
            OP_CREATE: begin
              if (rst != TS_FREE) begin
                stat_nxt = SC_INUSE;
                state_nxt = S_FIN;
              end else begin
                tw_nxt.lvl = nl_r;
                tw_nxt.used = 8'd0;
                tw_nxt.st = TS_READY;
                f_push_nxt = 1'b1;
                pl_nxt = nl_r;
                f_wr_nxt = 1'b1;
              end
            end
            OP_SETLVL: begin
              if (rst == TS_FREE) begin
                stat_nxt = SC_NOTFOUND;
                state_nxt = S_FIN;
              end else begin
                tw_nxt.lvl = nl_r;
                tw_nxt.used = 8'd0;
                if (rst == TS_READY) begin
                  f_unl_nxt = 1'b1;
                  ul_nxt = rd_r.lvl;
                  f_push_nxt = 1'b1;
                  pl_nxt = nl_r;
                end
                if (rst == TS_RUNNING) begin
                  cur_lvl_nxt = nl_r;
                end
                f_wr_nxt = 1'b1;
              end
            end
            OP_UNBLOCK: begin
              if (rst == TS_BLOCKED) begin
                tw_nxt.st = TS_READY;
                f_push_nxt = 1'b1;
                pl_nxt = rd_r.lvl;
                f_wr_nxt = 1'b1;
              end else begin
                stat_nxt = SC_NOTFOUND;
                state_nxt = S_FIN;
              end
            end
            OP_BLOCK: begin
              if (rst == TS_READY) begin
                f_unl_nxt = 1'b1;
                ul_nxt = rd_r.lvl;
                tw_nxt.st = TS_BLOCKED;
                f_wr_nxt = 1'b1;
              end else begin
                stat_nxt = SC_NOTFOUND;
                state_nxt = S_FIN;
              end
            end
            OP_KILL: begin
              if (rst == TS_RUNNING && cur_v_r && cur_r == t_r) begin
                oc_nxt = OC_TERM;
                state_nxt = S_AGE;
              end else if (rst == TS_READY) begin
                f_unl_nxt = 1'b1;
                ul_nxt = rd_r.lvl;
                tw_nxt.st = TS_FREE;
                f_wr_nxt = 1'b1;
              end else if (rst == TS_BLOCKED) begin
                tw_nxt.st = TS_FREE;
                f_wr_nxt = 1'b1;
              end else begin
                stat_nxt = SC_NOTFOUND;
                state_nxt = S_FIN;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      // aging counter
      S_AGE: begin
        if (17'(age_r) + 17'd1 >= 17'(period_r)) begin
          age_nxt = 16'd0;
          state_nxt = S_AG1;
        end else begin
          age_nxt = age_r + 16'd1;
          state_nxt = S_SETTLE;
        end
      end
      // splice level one behind level zero
      S_AG1: begin
        if (qc_r[1] == '0 || qc_r[0] == '0) begin
          shift = 1'b1;
          sw_nxt = '0;
          state_nxt = S_SWP;
        end else begin
          mem_raddr = qt_r[0];
          state_nxt = S_AG2;
        end
      end
      S_AG2: begin
        mem_we = 1'b1;
        mem_waddr = qt_r[0];
        mem_wdata = rd_r;
        mem_wdata.nxt = qh_r[1];
        mem_raddr = qh_r[1];
        state_nxt = S_AG3;
      end
      S_AG3: begin
        mem_we = 1'b1;
        mem_waddr = qh_r[1];
        mem_wdata = rd_r;
        mem_wdata.prv = qt_r[0];
        shift = 1'b1;
        sw_nxt = '0;
        state_nxt = S_SWP;
      end
      // relabel sweep, read one entry while writing back the one before
      S_SWP: begin
        if (32'(sw_r) < MAX_TASKS) begin
          mem_raddr = sw_r[IW-1:0];
        end
        if (sw_r != '0 && rvld_r && rd_r.st == TS_READY && rd_r.lvl != 2'd0) begin
          mem_we = 1'b1;
          mem_waddr = swm1[IW-1:0];
          mem_wdata = rd_r;
          mem_wdata.lvl = rd_r.lvl - 2'd1;
        end
        if (32'(sw_r) == MAX_TASKS) begin
          state_nxt = S_SETTLE;
        end else begin
          sw_nxt = sw_r + CW'(1);
        end
      end
      // settle the running task
      S_SETTLE: begin
        disp_nxt = 1'b1;
        if (cur_v_r) begin
          mem_raddr = cur_r;
          state_nxt = S_TKD;
        end else begin
          f_disp_nxt = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_TKD: begin
        t_nxt = cur_r;
        tw_nxt = rd_r;
        f_wr_nxt = 1'b1;
        f_disp_nxt = 1'b1;
        state_nxt = S_NEXT;
        case (oc_r)
          OC_RUN: begin
            tw_nxt.used = u2;
            if (u2 < quant_r[lv]) begin
              f_disp_nxt = 1'b0;
              disp_nxt = 1'b0;
            end else begin
              tw_nxt.lvl = (lv == 2'd3) ? 2'd3 : lv + 2'd1;
              tw_nxt.used = 8'd0;
              tw_nxt.st = TS_READY;
              f_push_nxt = 1'b1;
              pl_nxt = (lv == 2'd3) ? 2'd3 : lv + 2'd1;
            end
          end
          OC_YIELD: begin
            tw_nxt.st = TS_READY;
            f_push_nxt = 1'b1;
            pl_nxt = lv;
          end
          OC_BLOCK: begin
            if ({1'b0, rd_r.used} + 9'd1 < {1'b0, quant_r[lv]}) begin
              tw_nxt.lvl = (lv == 2'd0) ? 2'd0 : lv - 2'd1;
            end
            tw_nxt.used = 8'd0;
            tw_nxt.st = TS_BLOCKED;
          end
          default: tw_nxt.st = TS_FREE;
        endcase
      end
      // pending queue and table steps, in order
      S_NEXT: begin
        if (f_unl_r) begin
          state_nxt = S_UNL;
        end else if (f_push_r) begin
          state_nxt = S_PUSH;
        end else if (f_wr_r) begin
          state_nxt = S_WR;
        end else if (f_disp_r) begin
          state_nxt = S_DISP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // take the task out of its queue
      S_UNL: begin
        f_unl_nxt = 1'b0;
        state_nxt = S_NEXT;
        if (qc_r[ul_r] != '0) begin
          qc_nxt[ul_r] = qc_r[ul_r] - CW'(1);
          if (t_r == qh_r[ul_r]) begin
            if (qc_r[ul_r] > CW'(1)) begin
              qh_nxt[ul_r] = tw_r.nxt;
            end
          end else if (t_r == qt_r[ul_r]) begin
            qt_nxt[ul_r] = tw_r.prv;
          end else begin
            f_unl_nxt = 1'b1;
            mem_raddr = tw_r.prv;
            state_nxt = S_UNL2;
          end
        end
      end
      S_UNL2: begin
        mem_we = 1'b1;
        mem_waddr = tw_r.prv;
        mem_wdata = rd_r;
        mem_wdata.nxt = tw_r.nxt;
        mem_raddr = tw_r.nxt;
        state_nxt = S_UNL3;
      end
      S_UNL3: begin
        mem_we = 1'b1;
        mem_waddr = tw_r.nxt;
        mem_wdata = rd_r;
        mem_wdata.prv = tw_r.prv;
        f_unl_nxt = 1'b0;
        state_nxt = S_NEXT;
      end
      // append the task at the tail of its queue
      S_PUSH: begin
        if (qc_r[pl_r] == '0) begin
          qh_nxt[pl_r] = t_r;
          qt_nxt[pl_r] = t_r;
          qc_nxt[pl_r] = qc_r[pl_r] + CW'(1);
          f_push_nxt = 1'b0;
          state_nxt = S_NEXT;
        end else begin
          tw_nxt.prv = qt_r[pl_r];
          mem_raddr = qt_r[pl_r];
          state_nxt = S_PUSH2;
        end
      end
      S_PUSH2: begin
        mem_we = 1'b1;
        mem_waddr = qt_r[pl_r];
        mem_wdata = rd_r;
        mem_wdata.nxt = t_r;
        qt_nxt[pl_r] = t_r;
        qc_nxt[pl_r] = qc_r[pl_r] + CW'(1);
        f_push_nxt = 1'b0;
        state_nxt = S_NEXT;
      end
      S_WR: begin
        mem_we = 1'b1;
        f_wr_nxt = 1'b0;
        state_nxt = S_NEXT;
      end
      // pick the head of the best non-empty level
      S_DISP: begin
        for (int i = 3; i >= 0; i--) begin
          if (qc_r[i] != '0) begin
            found = 1'b1;
            fl = 2'(i);
          end
        end
        if (found) begin
          dl_nxt = fl;
          mem_raddr = qh_r[fl];
          qc_nxt[fl] = qc_r[fl] - CW'(1);
          state_nxt = S_DISP2;
        end else begin
          cur_v_nxt = 1'b0;
          cur_nxt = '0;
          cur_lvl_nxt = 2'd0;
          f_disp_nxt = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_DISP2: begin
        mem_we = 1'b1;
        mem_waddr = qh_r[dl_r];
        mem_wdata = rd_r;
        mem_wdata.st = TS_RUNNING;
        if (qc_r[dl_r] != '0) begin
          qh_nxt[dl_r] = rd_r.nxt;
        end
        cur_nxt = qh_r[dl_r];
        cur_v_nxt = 1'b1;
        cur_lvl_nxt = rd_r.lvl;
        f_disp_nxt = 1'b0;
        state_nxt = S_FIN;
      end
      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_task_nxt = 6'(cur_r);
          out_idle_nxt = !cur_v_r;
          out_lvl_nxt = cur_lvl_r;
          out_disp_nxt = disp_r;
          out_stat_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // aging moves each queue above level zero up one level, level one joining level zero
    if (shift) begin
      if (qc_r[1] != '0) begin
        if (qc_r[0] == '0) begin
          qh_nxt[0] = qh_r[1];
        end
        qt_nxt[0] = qt_r[1];
        qc_nxt[0] = qc_r[0] + qc_r[1];
      end
      qh_nxt[1] = qh_r[2];
      qt_nxt[1] = qt_r[2];
      qc_nxt[1] = qc_r[2];
      qh_nxt[2] = qh_r[3];
      qt_nxt[2] = qt_r[3];
      qc_nxt[2] = qc_r[3];
      qc_nxt[3] = '0;
    end

    // a written entry is valid from then on
    vld_nxt = vld_r;
    if (mem_we) begin
      vld_nxt[mem_waddr] = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      f_unl_r <= 1'b0;
      f_push_r <= 1'b0;
      f_wr_r <= 1'b0;
      f_disp_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        qh_r[i] <= '0;
        qt_r[i] <= '0;
        qc_r[i] <= '0;
      end
      quant_r[0] <= 8'd1;
      quant_r[1] <= 8'd2;
      quant_r[2] <= 8'd3;
      quant_r[3] <= 8'd4;
      period_r <= 16'd100;
      cur_r <= '0;
      cur_v_r <= 1'b0;
      cur_lvl_r <= 2'd0;
      age_r <= 16'd0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      f_unl_r <= f_unl_nxt;
      f_push_r <= f_push_nxt;
      f_wr_r <= f_wr_nxt;
      f_disp_r <= f_disp_nxt;
      qh_r <= qh_nxt;
      qt_r <= qt_nxt;
      qc_r <= qc_nxt;
      quant_r <= quant_nxt;
      period_r <= period_nxt;
      cur_r <= cur_nxt;
      cur_v_r <= cur_v_nxt;
      cur_lvl_r <= cur_lvl_nxt;
      age_r <= age_nxt;
      vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    oc_r <= oc_nxt;
    nl_r <= nl_nxt;
    idok_r <= idok_nxt;
    stat_r <= stat_nxt;
    disp_r <= disp_nxt;
    tw_r <= tw_nxt;
    t_r <= t_nxt;
    ul_r <= ul_nxt;
    pl_r <= pl_nxt;
    dl_r <= dl_nxt;
    sw_r <= sw_nxt;
    rvld_r <= vld_r[mem_raddr];
    out_task_r <= out_task_nxt;
    out_idle_r <= out_idle_nxt;
    out_lvl_r <= out_lvl_nxt;
    out_disp_r <= out_disp_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // checks
  `MLFQ_IMPLY(a_idle_clean, !cur_v_r, cur_r == '0 && cur_lvl_r == 2'd0)
  `MLFQ_NEXT(a_accept_dec, in_valid && !in_stall, state_r == S_DEC)
  `MLFQ_NEXT(a_fin_out, state_r == S_FIN && (!out_valid_r || !out_stall), out_valid_r && state_r == S_IDLE)
  `MLFQ_CHECK(a_out_idle, !out_valid || !out_idle || (out_running_task == 6'd0 && out_running_level == 2'd0))
endmodule
